[hdl/scdc_pkg.sv]
// Shared types and constants of the strip charge-division calibrator.
// Used by the coefficient memory, both divider pipelines and the top level.
package scdc_pkg;

  localparam int DETECTORS = 40;
  localparam int STRIPS    = 8;
  localparam int ENTRIES   = DETECTORS * STRIPS;
  localparam int ADDR_W    = $clog2(ENTRIES);

  // Quotient bits of the position and corrected-sum dividers.
  localparam int POS_STEPS = 15;
  localparam int SUM_STEPS = 24;
  // Width of a positive curve value in units of 2^-46.
  localparam int DEN_W     = 56;

  localparam logic [23:0] REF_ENERGY_RESET = 24'd1404416;
  localparam logic [23:0] SUM_MAX          = 24'hFFFFFF;

  // Configuration register indexes.
  localparam int REG_REFERENCE_ENERGY = 0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_HIT  = 1'b1
  } op_e;

  typedef logic [ADDR_W-1:0] addr_t;

  // One coefficient memory entry.
  typedef struct packed {
    logic [15:0]        gain_l;
    logic [15:0]        gain_r;
    logic signed [23:0] c0;
    logic signed [23:0] c1;
    logic signed [23:0] c2;
  } coef_t;

  // Identity and gained energies of one hit.
  typedef struct packed {
    logic [5:0]  det;
    logic [2:0]  strip;
    logic [19:0] left;
    logic [19:0] right;
  } hit_t;

  // Stage contents of the position divider.
  // A zero left energy puts the hit at the right end, a position of exactly -1.
  typedef struct packed {
    hit_t               hit;
    logic signed [23:0] c0;
    logic signed [23:0] c1;
    logic signed [23:0] c2;
    logic [20:0]        sum;
    logic               neg;
    logic               full;
    logic [20:0]        rem;
    logic [POS_STEPS-1:0] quo;
  } pd_t;

  // Stage contents of the corrected-sum divider.
  typedef struct packed {
    hit_t             hit;
    logic [15:0]      pos;
    logic             bad;
    logic             sat;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [SUM_STEPS-1:0] quo;
  } sd_t;

endpackage

[hdl/scdc_coef_mem.sv]
// Coefficient memory: one entry of gains and curve terms per detector strip.
// Synchronous write, synchronous read with registered data; uses scdc_pkg.
module scdc_coef_mem (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  scdc_pkg::addr_t      waddr_i,
  input  scdc_pkg::coef_t      wdata_i,
  input  logic                 re_i,
  input  scdc_pkg::addr_t      raddr_i,
  output scdc_pkg::coef_t      rdata_o
);
  import scdc_pkg::*;

  coef_t mem_q [ENTRIES];
  coef_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/scdc_pos_div.sv]
// Position divider: restoring division of |L-R|*2^15 by L+R, one bit a stage.
// Uses scdc_pkg; the pipeline advances only when en_i is high.
module scdc_pos_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  scdc_pkg::pd_t    data_i,
  output logic             valid_o,
  output scdc_pkg::pd_t    data_o
);
  import scdc_pkg::*;

  logic valid_q [POS_STEPS];
  pd_t  st_q    [POS_STEPS];

  for (genvar k = 0; k < POS_STEPS; k++) begin : g_step
    pd_t         src;
    logic        src_v;
    pd_t         st_d;
    logic [21:0] r2;

    if (k == 0) begin : g_first
      assign src   = data_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[k-1];
      assign src_v = valid_q[k-1];
    end

    // Shift the remainder and try to subtract the sum.
    always_comb begin
      st_d = src;
      r2   = {src.rem, 1'b0};
      if (r2 >= {1'b0, src.sum}) begin
        st_d.rem = 21'(r2 - {1'b0, src.sum});
        st_d.quo = {src.quo[POS_STEPS-2:0], 1'b1};
      end else begin
        st_d.rem = r2[20:0];
        st_d.quo = {src.quo[POS_STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign valid_o = valid_q[POS_STEPS-1];
  assign data_o  = st_q[POS_STEPS-1];

endmodule

[hdl/scdc_sum_div.sv]
// Corrected-sum divider: restoring division by the curve value, one bit a stage.
// Uses scdc_pkg; the remainder starts below the divisor, so it stays DEN_W wide.
module scdc_sum_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  scdc_pkg::sd_t    data_i,
  output logic             valid_o,
  output scdc_pkg::sd_t    data_o
);
  import scdc_pkg::*;

  logic valid_q [SUM_STEPS];
  sd_t  st_q    [SUM_STEPS];

  for (genvar k = 0; k < SUM_STEPS; k++) begin : g_step
    sd_t          src;
    logic         src_v;
    sd_t          st_d;
    logic [DEN_W:0] r2;

    if (k == 0) begin : g_first
      assign src   = data_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[k-1];
      assign src_v = valid_q[k-1];
    end

    // Shift the remainder and try to subtract the curve value.
    always_comb begin
      st_d = src;
      r2   = {src.rem, 1'b0};
      if (r2 >= {1'b0, src.den}) begin
        st_d.rem = DEN_W'(r2 - {1'b0, src.den});
        st_d.quo = {src.quo[SUM_STEPS-2:0], 1'b1};
      end else begin
        st_d.rem = r2[DEN_W-1:0];
        st_d.quo = {src.quo[SUM_STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign valid_o = valid_q[SUM_STEPS-1];
  assign data_o  = st_q[SUM_STEPS-1];

endmodule

[hdl/strip_charge_division_calibrator_unit.sv]
// Top level of the strip charge-division calibrator.
// Instantiates scdc_coef_mem, scdc_pos_div and scdc_sum_div; uses scdc_pkg.
//
// Usage: items arrive on the s_axis stream. tuser selects the kind: a load
// item writes one strip's gains and curve terms into the coefficient memory,
// a hit item reads that entry and yields at most one result on m_axis. A hit
// must only address an entry that was loaded before. Hits with a zero gained
// right energy or an address outside the detector array give no result.
// The reference energy is written through the APB port at byte address 0.
// Throughput: one item per cycle while m_axis is not stalled. From input
// accept to result valid an item passes a memory read, the gain multiply, 15
// stages of the position divider, two stages forming the curve value and 24
// stages of the corrected-sum divider, then the output register.
// The whole pipeline shares one advance enable: when the receiver holds
// m_axis_tready low with a result pending, every stage freezes and s_axis
// tready drops, so nothing is lost. Reset clears all valid flags and loads
// the reference energy with its default; the memory contents stay unknown.
module strip_charge_division_calibrator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input item stream.
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // tdata: detector[5:0], strip_index[8:6], energy_left[24:9],
  // energy_right[40:25], gain_left[56:41], gain_right[72:57],
  // curve_c0[96:73], curve_c1[120:97], curve_c2[144:121], zero pad
  input  logic [151:0]  s_axis_tdata_i,
  // tuser: op[0]
  input  logic          s_axis_tuser_i,
  // Result item stream.
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // tdata: hit_detector[5:0], hit_strip[8:6], left_calibrated[28:9],
  // right_calibrated[48:29], position[64:49], corrected_sum[88:65], zero pad
  output logic [95:0]   m_axis_tdata_o,
  // tuser: bad_denominator[0]
  output logic          m_axis_tuser_o,
  // Configuration port.
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import scdc_pkg::*;

  // Configuration register.
  logic [23:0] ref_energy_q;
  logic        reg_sel;

  assign reg_sel = (32'(paddr[2]) == 32'(REG_REFERENCE_ENERGY)) && (paddr[1:0] == 2'b00);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {8'b0, ref_energy_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_energy_q <= REF_ENERGY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      ref_energy_q <= pwdata[23:0];
    end
  end

  // Input unpacking and address check.
  logic        adv;
  logic        in_acc;
  logic [5:0]  in_det;
  logic [2:0]  in_strip;
  logic        in_range;
  addr_t       in_addr;
  coef_t       wr_coef;
  coef_t       rd_coef;

  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign in_acc          = s_axis_tvalid_i && adv;
  assign in_det          = s_axis_tdata_i[5:0];
  assign in_strip        = s_axis_tdata_i[8:6];
  assign in_range        = ({1'b0, in_det} < 7'(DETECTORS)) &&
                           ({2'b0, in_strip} < 5'(STRIPS));
  assign in_addr         = ADDR_W'(int'(in_det) * STRIPS + int'(in_strip));

  assign wr_coef.gain_l = s_axis_tdata_i[56:41];
  assign wr_coef.gain_r = s_axis_tdata_i[72:57];
  assign wr_coef.c0     = s_axis_tdata_i[96:73];
  assign wr_coef.c1     = s_axis_tdata_i[120:97];
  assign wr_coef.c2     = s_axis_tdata_i[144:121];

  scdc_coef_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && (op_e'(s_axis_tuser_i) == OP_LOAD) && in_range),
    .waddr_i (in_addr),
    .wdata_i (wr_coef),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (rd_coef)
  );

  // Stage 1: hit identity and raw energies, aligned with the memory read.
  logic        v1_q;
  logic [5:0]  det1_q;
  logic [2:0]  strip1_q;
  logic [15:0] el1_q, er1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i && (op_e'(s_axis_tuser_i) == OP_HIT) && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det1_q   <= in_det;
      strip1_q <= in_strip;
      el1_q    <= s_axis_tdata_i[24:9];
      er1_q    <= s_axis_tdata_i[40:25];
    end
  end

  // Stage 2: apply the end gains.
  logic        v2_q;
  hit_t        hit2_q;
  logic signed [23:0] c0_2_q, c1_2_q, c2_2_q;
  logic [31:0] prod_l, prod_r;

  assign prod_l = el1_q * rd_coef.gain_l;
  assign prod_r = er1_q * rd_coef.gain_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit2_q.det   <= det1_q;
      hit2_q.strip <= strip1_q;
      hit2_q.left  <= prod_l[31:12];
      hit2_q.right <= prod_r[31:12];
      c0_2_q       <= rd_coef.c0;
      c1_2_q       <= rd_coef.c1;
      c2_2_q       <= rd_coef.c2;
    end
  end

  // Sum and difference magnitude feed the position divider.
  pd_t  pd_in, pd_out;
  logic pd_in_v, pd_out_v;

  always_comb begin
    pd_in.hit  = hit2_q;
    pd_in.c0   = c0_2_q;
    pd_in.c1   = c1_2_q;
    pd_in.c2   = c2_2_q;
    pd_in.sum  = {1'b0, hit2_q.left} + {1'b0, hit2_q.right};
    pd_in.neg  = hit2_q.left < hit2_q.right;
    pd_in.full = (hit2_q.left == 20'd0);
    pd_in.rem  = pd_in.neg ? {1'b0, hit2_q.right - hit2_q.left}
                           : {1'b0, hit2_q.left - hit2_q.right};
    pd_in.quo  = '0;
  end

  assign pd_in_v = v2_q && (hit2_q.right != 20'd0);

  scdc_pos_div u_pos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pd_in_v),
    .data_i  (pd_in),
    .valid_o (pd_out_v),
    .data_o  (pd_out)
  );

  // Curve stage 1: signed position, first products, scaled energy sum.
  // A hit at the right end has the full negative position, one past the quotient range.
  logic signed [15:0] pos_c;
  logic        v3_q;
  hit_t        hit3_q;
  logic signed [15:0] pos3_q;
  logic signed [23:0] c0_3_q, c2_3_q;
  logic signed [39:0] m1_3_q;
  logic [30:0] pp3_q;
  logic [44:0] a3_q;
  logic signed [31:0] pp_full;

  assign pos_c   = pd_out.full ? 16'sh8000 :
                   pd_out.neg  ? -$signed({1'b0, pd_out.quo}) : $signed({1'b0, pd_out.quo});
  assign pp_full = pos_c * pos_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= pd_out_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit3_q <= pd_out.hit;
      pos3_q <= pos_c;
      c0_3_q <= pd_out.c0;
      c2_3_q <= pd_out.c2;
      m1_3_q <= pd_out.c1 * pos_c;
      pp3_q  <= pp_full[30:0];
      a3_q   <= pd_out.sum * ref_energy_q;
    end
  end

  // Curve stage 2: align the three terms in units of 2^-46.
  logic        v4_q;
  hit_t        hit4_q;
  logic [15:0] pos4_q;
  logic [44:0] a4_q;
  logic signed [56:0] t0_4_q, t1_4_q, t2_4_q;
  logic signed [55:0] t2_c;

  assign t2_c = c2_3_q * $signed({1'b0, pp3_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit4_q <= hit3_q;
      pos4_q <= pos3_q;
      a4_q   <= a3_q;
      t0_4_q <= {{3{c0_3_q[23]}}, c0_3_q, 30'b0};
      t1_4_q <= {{2{m1_3_q[39]}}, m1_3_q, 15'b0};
      t2_4_q <= {t2_c[55], t2_c};
    end
  end

  // Curve value, sign check and saturation check feed the sum divider.
  logic signed [56:0] den_c;
  logic [66:0] num_c;
  sd_t  sd_in, sd_out;
  logic sd_out_v;

  assign den_c = t0_4_q + t1_4_q + t2_4_q;
  assign num_c = {a4_q, 22'b0};

  always_comb begin
    sd_in.hit = hit4_q;
    sd_in.pos = pos4_q;
    sd_in.bad = den_c[56] || (den_c == 57'sd0);
    sd_in.den = den_c[DEN_W-1:0];
    sd_in.sat = !sd_in.bad && (num_c >= {11'b0, den_c[DEN_W-1:0]});
    sd_in.rem = (sd_in.bad || sd_in.sat) ? '0 : num_c[DEN_W-1:0];
    sd_in.quo = '0;
  end

  scdc_sum_div u_sum_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .data_i  (sd_in),
    .valid_o (sd_out_v),
    .data_o  (sd_out)
  );

  // Output register.
  logic        m_valid_q;
  logic [95:0] m_data_q;
  logic        m_bad_q;
  logic [23:0] corr_c;

  always_comb begin
    priority if (sd_out.bad) begin
      corr_c = '0;
    end else if (sd_out.sat) begin
      corr_c = SUM_MAX;
    end else begin
      corr_c = sd_out.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= sd_out_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {7'b0, corr_c, sd_out.pos, sd_out.hit.right, sd_out.hit.left,
                   sd_out.hit.strip, sd_out.hit.det};
      m_bad_q  <= sd_out.bad;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_bad_q;

endmodule
